>>> rtl/lgrs_pkg.sv
package lgrs_pkg;

  // Cells per row and width of the grid_width register
  localparam int ROW_CELLS = 64;
  localparam int WIDTH_W   = 7;

  // Depth of the queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  typedef logic [ROW_CELLS-1:0] row_t;
  typedef logic [WIDTH_W-1:0]   width_t;

  // One queued job: the three rows that one accepted row brings to light.
  // has_first: evolve mid with up above and down below (final_row 0).
  // last:      evolve down with mid above and dead below (final_row 1).
  typedef struct packed {
    row_t up;
    row_t mid;
    row_t down;
    logic has_first;
    logic last;
  } job_t;

  // Mask of the columns in use; widths beyond the row saturate
  function automatic row_t width_mask(input width_t w);
    row_t m;
    m = '0;
    for (int i = 0; i < ROW_CELLS; i++) begin
      m[i] = (int'(w) > i);
    end
    return m;
  endfunction

endpackage

>>> rtl/lgrs_front.sv
module lgrs_front import lgrs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  row_t mask,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [ROW_CELLS-1:0] in_tdata,  // row_cells
  input  logic in_tlast,                  // last_row
  input  logic q_full,
  output logic q_push,
  output job_t q_job
);

  row_t above_r, above_nxt;
  row_t mid_r, mid_nxt;
  logic mv_r, mv_nxt;
  row_t row;
  logic accept;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign row       = in_tdata & mask;

  // Classify the row: queue a job whenever it releases at least one result
  always_comb begin
    q_push          = accept && (mv_r || in_tlast);
    q_job.up        = above_r;
    q_job.mid       = mid_r;
    q_job.down      = row;
    q_job.has_first = mv_r;
    q_job.last      = in_tlast;
  end

  // Advance the row window; the last row starts a fresh generation
  always_comb begin
    above_nxt = above_r;
    mid_nxt   = mid_r;
    mv_nxt    = mv_r;
    if (accept) begin
      if (in_tlast) begin
        above_nxt = '0;
        mid_nxt   = '0;
        mv_nxt    = 1'b0;
      end else begin
        above_nxt = mid_r;
        mid_nxt   = row;
        mv_nxt    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      above_r <= '0;
      mid_r   <= '0;
      mv_r    <= 1'b0;
    end else begin
      above_r <= above_nxt;
      mid_r   <= mid_nxt;
      mv_r    <= mv_nxt;
    end
  end

endmodule

>>> rtl/lgrs_queue.sv
module lgrs_queue import lgrs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head_job
);

  job_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;
  logic               do_push, do_pop;

  assign full       = (count_r == Q_CNT_W'(Q_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the job; payload needs no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CNT_W'(Q_DEPTH))
    else $error("queue fill level beyond depth");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue fill level did not grow on push");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == Q_CNT_W'(Q_DEPTH)) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with fill level");
`endif

endmodule

>>> rtl/lgrs_back.sv
module lgrs_back import lgrs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  row_t mask,
  input  logic job_valid,
  input  job_t job,
  output logic pop,
  output logic out_tvalid,
  input  logic out_tready,
  output logic [ROW_CELLS-1:0] out_tdata,  // next_row
  output logic out_tlast                   // final_row
);

  logic phase_r, phase_nxt;
  logic out_valid_r, out_valid_nxt;
  row_t data_r, data_nxt;
  logic last_r, last_nxt;
  logic load, second;
  row_t up_sel, mid_sel, down_sel;

  // Next generation of one row, all columns in parallel
  function automatic row_t evolve(input row_t up, input row_t mid, input row_t down,
                                  input row_t m);
    logic [ROW_CELLS+1:0] pu, pm, pd;
    logic [3:0]           n;
    row_t                 res;
    pu  = {1'b0, up & m, 1'b0};
    pm  = {1'b0, mid & m, 1'b0};
    pd  = {1'b0, down & m, 1'b0};
    res = '0;
    for (int c = 0; c < ROW_CELLS; c++) begin
      n = 4'(pu[c]) + 4'(pu[c+1]) + 4'(pu[c+2])
        + 4'(pm[c]) + 4'(pm[c+2])
        + 4'(pd[c]) + 4'(pd[c+1]) + 4'(pd[c+2]);
      res[c] = (n == 4'd3) || (pm[c+1] && (n == 4'd2));
    end
    return res & m;
  endfunction

  assign load   = !out_valid_r || out_tready;
  assign second = phase_r || !job.has_first;

  // Pick the row window for this result
  always_comb begin
    up_sel   = second ? job.mid  : job.up;
    mid_sel  = second ? job.down : job.mid;
    down_sel = second ? '0       : job.down;
  end

  // Issue one result per free output slot; drop the job after its last one
  always_comb begin
    pop           = 1'b0;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r;
    data_nxt      = data_r;
    last_nxt      = last_r;
    if (load) begin
      out_valid_nxt = job_valid;
      if (job_valid) begin
        data_nxt  = evolve(up_sel, mid_sel, down_sel, mask);
        last_nxt  = second;
        pop       = second || !job.last;
        phase_nxt = second ? 1'b0 : job.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the result until the transfer completes
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;

`ifndef SYNTHESIS
  a_phase_job: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> (job_valid && job.has_first && job.last))
    else $error("second result pending without a two-result job");

  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (load && job_valid && job.has_first && job.last && !phase_r) |-> !pop)
    else $error("two-result job dropped after its first result");

  a_pop_load: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (load && job_valid))
    else $error("job dropped without a result issued");
`endif

endmodule

>>> rtl/life_generation_row_stream.sv
// One generation of Life (born on 3, survives on 2 or 3) over a grid of up to
// 64 columns with dead borders and no wrap. Send the rows top to bottom on
// in_tdata, bit i being column i, with in_tlast on the bottom row. Each row
// after the first gives the next generation of the row above it; the bottom
// row also gives its own, flagged with out_tlast, so a grid of R rows yields
// R results and the next transfer starts a new grid. Rows are taken at one a
// cycle while the job queue is not full; a bottom row yields two results and
// so takes the single output port twice, which a two-entry job queue between
// the row window and the cell evaluator absorbs. A result is held in the job
// queue and then in the output register. Columns at or beyond grid_width
// (cfg_wdata, reset 64, values above 64 act as 64) read as dead and come out
// as zero; change it only between grids, with no result outstanding.
module life_generation_row_stream import lgrs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [WIDTH_W-1:0] cfg_wdata,    // grid_width
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [ROW_CELLS-1:0] in_tdata,   // row_cells
  input  logic in_tlast,                   // last_row
  output logic out_tvalid,
  input  logic out_tready,
  output logic [ROW_CELLS-1:0] out_tdata,  // next_row
  output logic out_tlast                   // final_row
);

  width_t grid_width_r, grid_width_nxt;
  row_t   mask;
  logic   q_push, q_full, q_pop, q_head_valid;
  job_t   q_job, q_head_job;

  // Hold the width register
  assign grid_width_nxt = cfg_we ? cfg_wdata : grid_width_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r <= WIDTH_W'(ROW_CELLS);
    end else begin
      grid_width_r <= grid_width_nxt;
    end
  end

  assign mask = width_mask(grid_width_r);

  lgrs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .mask      (mask),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_job)
  );

  lgrs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_job   (q_head_job)
  );

  lgrs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .mask       (mask),
    .job_valid  (q_head_valid),
    .job        (q_head_job),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
